// File: design/tkct_pkg.sv
package tkct_pkg;

   localparam int ENTRY_W = 129;
   localparam int TICK_W = 32;
   localparam int FIELD_W = 32;
   localparam int AIRCRAFT_W = 8;
   localparam int COUNT_W = 7;

   localparam logic [1:0] OP_SUBMIT = 2'd0;
   localparam logic [1:0] OP_PEEK = 2'd1;
   localparam logic [1:0] OP_CONSUME = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_STALE = 2'd2;
   localparam logic [1:0] STATUS_BEYOND = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;
   localparam logic [TICK_W-1:0] TICK_MAX = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_READ,
      ST_EVAL,
      ST_WRITE,
      ST_RESP
   } state_type;

endpackage

// File: design/tkct_ram.sv
module tkct_ram
   import tkct_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/tick_keyed_command_table.sv
// A request is accepted in the cycle after the previous result is loaded into the output register.
// Each request passes the modulo, read and evaluate states before its result is loaded; a submit
// that reaches the table also passes the write state. A stalled result holds off the next request.
// The modulo state forms the ring row from the tick times the reciprocal of the window size.
// Reset clears the floor, sets the aircraft count to 64 and clears the per-row live bits at once;
// the tag, valid-word and command memories need no clearing pass.
module tick_keyed_command_table
   import tkct_pkg::*;
#(
   parameter int MAX_AIRCRAFT = 64,
   parameter int TICK_WINDOW = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_op,
   input  logic [TICK_W-1:0]      req_tick,
   input  logic [AIRCRAFT_W-1:0]  req_aircraft,
   input  logic [FIELD_W-1:0]     req_seq,
   input  logic signed [FIELD_W-1:0] req_phi_q,
   input  logic signed [FIELD_W-1:0] req_g_q,
   input  logic signed [FIELD_W-1:0] req_throttle_q,
   input  logic                   req_fire_flag,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic                   rsp_found,
   output logic [FIELD_W-1:0]     rsp_out_seq,
   output logic signed [FIELD_W-1:0] rsp_out_phi,
   output logic signed [FIELD_W-1:0] rsp_out_g,
   output logic signed [FIELD_W-1:0] rsp_out_throttle,
   output logic                   rsp_out_fire,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [COUNT_W-1:0]     csr_data
);

   localparam int ROW_W = $clog2(TICK_WINDOW);
   localparam int SLOTS = TICK_WINDOW * MAX_AIRCRAFT;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int AC_W = (MAX_AIRCRAFT > 1) ? $clog2(MAX_AIRCRAFT) : 1;
   localparam int ROW_DATA_W = TICK_W + MAX_AIRCRAFT;
   localparam int SHIFT_C = TICK_W + ROW_W;
   localparam int RECIP_W = TICK_W + 1;
   localparam int PROD_W = TICK_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(((64'd1 << SHIFT_C)
                                             + 64'(TICK_WINDOW) - 64'd1) / 64'(TICK_WINDOW));
   localparam logic [ROW_W-1:0] WIN_LO_C = TICK_WINDOW[ROW_W-1:0];
   localparam logic [AIRCRAFT_W-1:0] MAX_AC_C = MAX_AIRCRAFT[AIRCRAFT_W-1:0];
   localparam logic [SLOT_W-1:0] MAX_SLOT_C = MAX_AIRCRAFT[SLOT_W-1:0];

   state_type state_ff, state_in;

   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [TICK_W-1:0]     floor_ff, floor_in;
   logic [TICK_WINDOW-1:0] live_ff, live_in;

   logic [1:0]            op_ff;
   logic [TICK_W-1:0]     tick_ff;
   logic [AIRCRAFT_W-1:0] ac_ff;
   logic [ENTRY_W-1:0]    cand_ff;

   logic                  cnt_ff, cnt_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [ROW_W-1:0]      rem_ff, rem_in;
   logic                  stale_ff, stale_in;
   logic                  beyond_ff, beyond_in;
   logic [1:0]            status_ff, status_in;
   logic                  found_ff, found_in;
   logic                  present_ff, present_in;
   logic                  rank_ff, rank_in;
   logic [MAX_AIRCRAFT-1:0] base_ff, base_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff;
   logic                  rsp_found_ff;
   logic [ENTRY_W-1:0]    rsp_entry_ff;
   logic                  rsp_load;

   logic                  row_rd_en, row_wr_en;
   logic [ROW_DATA_W-1:0] row_wr_data, row_rd_data;
   logic                  store_rd_en, store_wr_en;
   logic [SLOT_W-1:0]     slot_addr;
   logic [ENTRY_W-1:0]    store_rd_data;

   logic [ROW_W-1:0]      quot_lo;
   logic [TICK_W-1:0]     row_tag;
   logic [MAX_AIRCRAFT-1:0] row_bits, eff_bits, ac_bit;
   logic                  tag_hit, ac_ok, range_bad;
   logic [TICK_W-1:0]     next_floor;

   function automatic logic [ENTRY_W-1:0] rank_key(input logic [ENTRY_W-1:0] e);
      logic [ENTRY_W-1:0] k;
      k = e;
      k[96] = ~e[96];
      k[64] = ~e[64];
      k[32] = ~e[32];
      return k;
   endfunction

   tkct_ram #(
      .WIDTH(ROW_DATA_W),
      .DEPTH(TICK_WINDOW)
   ) u_row_ram (
      .clock  (clock),
      .wr_en  (row_wr_en),
      .wr_addr(rem_ff),
      .wr_data(row_wr_data),
      .rd_en  (row_rd_en),
      .rd_addr(rem_ff),
      .rd_data(row_rd_data)
   );

   tkct_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(SLOTS)
   ) u_store_ram (
      .clock  (clock),
      .wr_en  (store_wr_en),
      .wr_addr(slot_addr),
      .wr_data(cand_ff),
      .rd_en  (store_rd_en),
      .rd_addr(slot_addr),
      .rd_data(store_rd_data)
   );

   assign slot_addr = SLOT_W'(rem_ff) * MAX_SLOT_C + SLOT_W'(ac_ff[AC_W-1:0]);
   assign quot_lo = prod_ff[SHIFT_C +: ROW_W];
   assign row_tag = row_rd_data[ROW_DATA_W-1:MAX_AIRCRAFT];
   assign row_bits = row_rd_data[MAX_AIRCRAFT-1:0];
   assign tag_hit = live_ff[rem_ff] && (row_tag == tick_ff);
   assign eff_bits = tag_hit ? row_bits : '0;
   assign ac_bit = MAX_AIRCRAFT'(1) << ac_ff[AC_W-1:0];
   assign ac_ok = ac_ff < MAX_AC_C;
   assign range_bad = (ac_ff >= {1'b0, count_ff}) || !ac_ok;
   assign next_floor = (tick_ff == TICK_MAX) ? TICK_MAX : tick_ff + 32'd1;
   assign row_wr_data = {tick_ff, base_ff | ac_bit};
   assign rsp_load = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= COUNT_RESET;
         floor_ff <= '0;
         live_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         floor_ff <= floor_in;
         live_ff <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         op_ff <= req_op;
         tick_ff <= req_tick;
         ac_ff <= req_aircraft;
         cand_ff <= {req_seq, req_phi_q, req_g_q, req_throttle_q, req_fire_flag};
      end
      cnt_ff <= cnt_in;
      prod_ff <= prod_in;
      rem_ff <= rem_in;
      stale_ff <= stale_in;
      beyond_ff <= beyond_in;
      status_ff <= status_in;
      found_ff <= found_in;
      present_ff <= present_in;
      rank_ff <= rank_in;
      base_ff <= base_in;
      if (state_ff == ST_RESP && rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff <= found_ff;
         rsp_entry_ff <= found_ff ? store_rd_data : '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = (csr_valid && csr_ready) ? csr_data : count_ff;
      floor_in = floor_ff;
      live_in = live_ff;
      cnt_in = cnt_ff;
      prod_in = prod_ff;
      rem_in = rem_ff;
      stale_in = stale_ff;
      beyond_in = beyond_ff;
      status_in = status_ff;
      found_in = found_ff;
      present_in = present_ff;
      rank_in = rank_ff;
      base_in = base_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      row_rd_en = 1'b0;
      row_wr_en = 1'b0;
      store_rd_en = 1'b0;
      store_wr_en = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cnt_in = 1'b0;
               rem_in = '0;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (!cnt_ff) begin
               stale_in = tick_ff < floor_ff;
               beyond_in = {1'b0, tick_ff} >= ({1'b0, floor_ff} + 33'(TICK_WINDOW));
               prod_in = PROD_W'(tick_ff) * PROD_W'(RECIP_C);
               cnt_in = 1'b1;
            end else begin
               rem_in = tick_ff[ROW_W-1:0] - ROW_W'(quot_lo * WIN_LO_C);
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            row_rd_en = 1'b1;
            store_rd_en = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            status_in = STATUS_OK;
            found_in = 1'b0;
            state_in = ST_RESP;
            case (op_ff)
               OP_SUBMIT: begin
                  if (range_bad) begin
                     status_in = STATUS_RANGE;
                  end else if (stale_ff) begin
                     status_in = STATUS_STALE;
                  end else if (beyond_ff) begin
                     status_in = STATUS_BEYOND;
                  end else begin
                     base_in = eff_bits;
                     present_in = |(eff_bits & ac_bit);
                     rank_in = rank_key(store_rd_data) < rank_key(cand_ff);
                     state_in = ST_WRITE;
                  end
               end
               OP_PEEK: begin
                  found_in = ac_ok && |(eff_bits & ac_bit);
               end
               OP_CONSUME: begin
                  if (tag_hit) begin
                     live_in[rem_ff] = 1'b0;
                  end
                  if (floor_ff < next_floor) begin
                     floor_in = next_floor;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_WRITE: begin
            row_wr_en = 1'b1;
            live_in[rem_ff] = 1'b1;
            store_wr_en = !present_ff || rank_ff;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_out_seq = rsp_entry_ff[128:97];
   assign rsp_out_phi = rsp_entry_ff[96:65];
   assign rsp_out_g = rsp_entry_ff[64:33];
   assign rsp_out_throttle = rsp_entry_ff[32:1];
   assign rsp_out_fire = rsp_entry_ff[0];

endmodule

// File: test/tb_tick_keyed_command_table.sv
`timescale 1ns / 100ps

module tb_tick_keyed_command_table;
   import tkct_pkg::*;

   localparam int TABLE_ROWS = 16;
   localparam int SLOTS = 64;
   localparam int PHASE_REQUESTS = 68;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [FIELD_W-1:0]        seq;
      logic signed [FIELD_W-1:0] phi;
      logic signed [FIELD_W-1:0] g;
      logic signed [FIELD_W-1:0] throttle;
      logic                      fire;
   } command_entry_type;

   typedef struct packed {
      logic [1:0]            op;
      logic [TICK_W-1:0]     tick;
      logic [AIRCRAFT_W-1:0] aircraft;
      command_entry_type     cmd;
   } table_request_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              found;
      command_entry_type entry;
   } table_response_type;

   class command_table_scoreboard;
      logic [COUNT_W-1:0] aircraft_count;
      logic [TICK_W-1:0]  floor_tick;
      logic [TICK_W-1:0]  row_tag [TABLE_ROWS];
      logic [SLOTS-1:0]   row_live [TABLE_ROWS];
      command_entry_type  slot [TABLE_ROWS*SLOTS];
      table_response_type expected_q [$];
      int                 failures;
      int                 checked;
      int                 peek_hits;

      function new();
         aircraft_count = COUNT_RESET;
         floor_tick = '0;
         foreach (row_tag[i]) begin
            row_tag[i] = '0;
            row_live[i] = '0;
         end
         failures = 0;
         checked = 0;
         peek_hits = 0;
      endfunction

      function void set_count(logic [COUNT_W-1:0] value);
         aircraft_count = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function bit ranks_below(command_entry_type held, command_entry_type cand);
         if (held.seq != cand.seq) return held.seq < cand.seq;
         if (held.phi != cand.phi) return $signed(held.phi) < $signed(cand.phi);
         if (held.g != cand.g) return $signed(held.g) < $signed(cand.g);
         if (held.throttle != cand.throttle) begin
            return $signed(held.throttle) < $signed(cand.throttle);
         end
         return held.fire < cand.fire;
      endfunction

      function void note_request(table_request_type r);
         table_response_type want;
         int                 row;
         int                 k;
         logic [TICK_W:0]    limit;
         logic [TICK_W-1:0]  next_floor;
         want = '0;
         row = r.tick % TABLE_ROWS;
         case (r.op)
            OP_SUBMIT: begin
               limit = {1'b0, floor_tick} + TABLE_ROWS;
               if (r.aircraft >= aircraft_count || r.aircraft >= SLOTS) begin
                  want.status = STATUS_RANGE;
               end else if (r.tick < floor_tick) begin
                  want.status = STATUS_STALE;
               end else if ({1'b0, r.tick} >= limit) begin
                  want.status = STATUS_BEYOND;
               end else begin
                  if (row_tag[row] != r.tick || row_live[row] == '0) begin
                     row_tag[row] = r.tick;
                     row_live[row] = '0;
                  end
                  k = row * SLOTS + r.aircraft;
                  if (!row_live[row][r.aircraft[5:0]] || ranks_below(slot[k], r.cmd)) begin
                     slot[k] = r.cmd;
                     row_live[row][r.aircraft[5:0]] = 1'b1;
                  end
                  want.status = STATUS_OK;
               end
            end
            OP_PEEK: begin
               if (r.aircraft < SLOTS && row_tag[row] == r.tick
                   && row_live[row][r.aircraft[5:0]]) begin
                  want.found = 1'b1;
                  want.entry = slot[row * SLOTS + r.aircraft];
                  peek_hits++;
               end
            end
            OP_CONSUME: begin
               next_floor = (r.tick == TICK_MAX) ? TICK_MAX : r.tick + 1;
               if (row_tag[row] == r.tick) row_live[row] = '0;
               if (floor_tick < next_floor) floor_tick = next_floor;
            end
            default: begin
            end
         endcase
         expected_q.push_back(want);
      endfunction

      function string show(table_response_type x);
         return $sformatf("status %0d found %0b seq %h phi %h g %h throttle %h fire %0b",
                          x.status, x.found, x.entry.seq, x.entry.phi, x.entry.g,
                          x.entry.throttle, x.entry.fire);
      endfunction

      function void check_response(table_response_type got);
         table_response_type want;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= 10) $display("Result with no request outstanding: %s", show(got));
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got !== want) begin
            failures++;
            if (failures <= 10) begin
               $display("Mismatch on result %0d:", checked);
               $display("  expected %s", show(want));
               $display("  actual   %s", show(got));
            end
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_op = OP_SUBMIT;
   logic [TICK_W-1:0]         req_tick = '0;
   logic [AIRCRAFT_W-1:0]     req_aircraft = '0;
   logic [FIELD_W-1:0]        req_seq = '0;
   logic signed [FIELD_W-1:0] req_phi_q = '0;
   logic signed [FIELD_W-1:0] req_g_q = '0;
   logic signed [FIELD_W-1:0] req_throttle_q = '0;
   logic                      req_fire_flag = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [1:0]                rsp_status;
   logic                      rsp_found;
   logic [FIELD_W-1:0]        rsp_out_seq;
   logic signed [FIELD_W-1:0] rsp_out_phi;
   logic signed [FIELD_W-1:0] rsp_out_g;
   logic signed [FIELD_W-1:0] rsp_out_throttle;
   logic                      rsp_out_fire;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [COUNT_W-1:0]        csr_data = '0;

   command_table_scoreboard sb;
   table_response_type      seen_rsp;
   bit                      quiet = 1'b0;
   int                      stall_left = 0;
   int                      sent = 0;
   int                      settings = 0;

   tick_keyed_command_table #(
      .MAX_AIRCRAFT(SLOTS),
      .TICK_WINDOW(TABLE_ROWS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_tick(req_tick),
      .req_aircraft(req_aircraft),
      .req_seq(req_seq),
      .req_phi_q(req_phi_q),
      .req_g_q(req_g_q),
      .req_throttle_q(req_throttle_q),
      .req_fire_flag(req_fire_flag),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_found(rsp_found),
      .rsp_out_seq(rsp_out_seq),
      .rsp_out_phi(rsp_out_phi),
      .rsp_out_g(rsp_out_g),
      .rsp_out_throttle(rsp_out_throttle),
      .rsp_out_fire(rsp_out_fire),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_rsp = {rsp_status, rsp_found, rsp_out_seq, rsp_out_phi, rsp_out_g,
                     rsp_out_throttle, rsp_out_fire};
         sb.check_response(seen_rsp);
      end
   end

   function automatic logic [FIELD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         4, 5: return $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   function automatic command_entry_type random_cmd();
      command_entry_type c;
      c.seq = pick_word();
      c.phi = pick_word();
      c.g = pick_word();
      c.throttle = pick_word();
      c.fire = 1'($urandom_range(0, 1));
      return c;
   endfunction

   function automatic logic [AIRCRAFT_W-1:0] pick_aircraft();
      int lim;
      lim = (sb.aircraft_count > SLOTS) ? SLOTS : sb.aircraft_count;
      case ($urandom_range(0, 9))
         0: return AIRCRAFT_W'($urandom_range(0, 255));
         1: return AIRCRAFT_W'(lim);
         2: return AIRCRAFT_W'((lim == 0) ? 0 : lim - 1);
         3, 4, 5: return AIRCRAFT_W'($urandom_range(0, 2));
         default: begin
            return AIRCRAFT_W'((lim == 0) ? $urandom_range(0, 255)
                                          : $urandom_range(0, lim - 1));
         end
      endcase
   endfunction

   function automatic table_request_type request_of(logic [1:0] op, logic [TICK_W-1:0] tick,
                                                    int aircraft, command_entry_type c);
      table_request_type r;
      r.op = op;
      r.tick = tick;
      r.aircraft = AIRCRAFT_W'(aircraft);
      r.cmd = c;
      return r;
   endfunction

   function automatic table_request_type random_request();
      table_request_type r;
      int                pick;
      logic [TICK_W-1:0] fl;
      fl = sb.floor_tick;
      r.cmd = random_cmd();
      r.aircraft = pick_aircraft();
      r.op = OP_SUBMIT;
      r.tick = fl + $urandom_range(0, TABLE_ROWS - 1);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
      end else if (pick < 65) begin
         r.op = OP_PEEK;
         if ($urandom_range(0, 3) == 0) r.tick = $urandom;
      end else if (pick < 75) begin
         r.op = OP_CONSUME;
         r.tick = fl + $urandom_range(0, 2);
         if (fl > 0 && $urandom_range(0, 3) == 0) r.tick = fl - 1;
      end else if (pick < 84) begin
         r.tick = (fl == 0) ? fl : $urandom_range(0, fl - 1);
      end else if (pick < 95) begin
         r.tick = ($urandom_range(0, 1) == 0) ? fl + TABLE_ROWS + $urandom_range(0, 40)
                                              : $urandom;
      end else begin
         r.op = OP_UNUSED;
         r.tick = $urandom;
         r.aircraft = AIRCRAFT_W'($urandom_range(0, 255));
      end
      return r;
   endfunction

   task automatic send_request(input table_request_type r);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= r.op;
      req_tick <= r.tick;
      req_aircraft <= r.aircraft;
      req_seq <= r.cmd.seq;
      req_phi_q <= r.cmd.phi;
      req_g_q <= r.cmd.g;
      req_throttle_q <= r.cmd.throttle;
      req_fire_flag <= r.cmd.fire;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_count(input logic [COUNT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_count(value);
      settings++;
      csr_valid <= 1'b0;
   endtask

   initial begin
      #2_000_000;
      $display("tick_keyed_command_table verification failed");
      $finish;
   end

   initial begin
      logic [COUNT_W-1:0] counts [6];
      command_entry_type  c;
      command_entry_type  first_cmd;
      command_entry_type  second_cmd;
      counts = '{7'd64, 7'd0, 7'd127, 7'd1, 7'd37, 7'd64};
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_count(COUNT_RESET);

      // Tag every row once so later peeks and consumes never see an unwritten tag.
      for (int i = 0; i < TABLE_ROWS; i++) begin
         c = random_cmd();
         c.seq = (i == 1) ? '1 : i;
         if (i == 1) begin
            c.phi = 32'h7FFF_FFFF;
            c.g = 32'h8000_0000;
            c.throttle = '1;
         end
         if (i == 2) begin
            c.phi = 32'h8000_0000;
            c.g = 32'h7FFF_FFFF;
            c.throttle = 32'h7FFF_FFFF;
         end
         c.fire = i[0];
         if (i == 1) first_cmd = c;
         if (i == 2) second_cmd = c;
         send_request(request_of(OP_SUBMIT, i, (i == TABLE_ROWS - 1) ? 63 : i % 4, c));
      end
      send_request(request_of(OP_PEEK, 1, 1, '0));
      send_request(request_of(OP_SUBMIT, 1, 1, first_cmd));
      c = first_cmd;
      c.seq = 32'hFFFF_FFFE;
      send_request(request_of(OP_SUBMIT, 1, 1, c));
      send_request(request_of(OP_PEEK, 1, 1, '0));
      c = second_cmd;
      c.fire = 1'b1;
      send_request(request_of(OP_SUBMIT, 2, 2, c));
      send_request(request_of(OP_PEEK, 2, 2, '0));
      send_request(request_of(OP_SUBMIT, 3, 64, random_cmd()));
      send_request(request_of(OP_SUBMIT, 3, 255, random_cmd()));
      send_request(request_of(OP_PEEK, 3, 200, '0));
      send_request(request_of(OP_SUBMIT, TABLE_ROWS, 0, random_cmd()));
      send_request(request_of(OP_CONSUME, 0, 0, '0));
      send_request(request_of(OP_SUBMIT, 0, 0, random_cmd()));
      send_request(request_of(OP_PEEK, 0, 0, '0));
      send_request(request_of(OP_CONSUME, 20, 0, '0));
      send_request(request_of(OP_PEEK, 4, 0, '0));
      send_request(request_of(OP_SUBMIT, 36, 0, random_cmd()));
      send_request(request_of(OP_PEEK, 4, 0, '0));
      send_request(request_of(OP_UNUSED, $urandom, 8'hFF, random_cmd()));

      foreach (counts[p]) begin
         drain();
         if (p == 5) quiet = 1'b1;
         write_count(counts[p]);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (!quiet && $urandom_range(0, 49) == 0) drain();
            send_request(random_request());
         end
      end

      // Top of the tick range, where the floor saturates.
      send_request(request_of(OP_CONSUME, 32'hFFFF_FFEE, 0, '0));
      send_request(request_of(OP_SUBMIT, TICK_MAX, 0, random_cmd()));
      send_request(request_of(OP_PEEK, TICK_MAX, 0, '0));
      send_request(request_of(OP_CONSUME, TICK_MAX, 0, '0));
      send_request(request_of(OP_SUBMIT, TICK_MAX, 1, random_cmd()));
      send_request(request_of(OP_PEEK, TICK_MAX, 1, '0));
      send_request(request_of(OP_SUBMIT, 32'hFFFF_FFFE, 1, random_cmd()));
      send_request(request_of(OP_CONSUME, TICK_MAX, 0, '0));
      send_request(request_of(OP_PEEK, TICK_MAX, 1, '0));

      drain();
      repeat (40) @(posedge clock);
      $display("Ran %0d requests over %0d aircraft-count settings; %0d results checked.",
               sent, settings, sb.checked);
      $display("Peeks found %0d stored commands; %0d failures seen.", sb.peek_hits,
               sb.failures);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("tick_keyed_command_table verification clean");
      end else begin
         $display("tick_keyed_command_table verification failed");
      end
      $finish;
   end

endmodule
